// ===== design/lcb_pkg.sv =====
// shared constants and types of the look-at camera basis block
`default_nettype none

package lcb_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 14;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQR,
        ST_SUM,
        ST_DIV,
        ST_SQL,
        ST_SQRT,
        ST_UPM,
        ST_DONE
    } state_t;

    // control of the normalize lanes
    typedef struct packed {
        logic load;
        logic div_en;
        logic div_first;
        logic sq_load;
        logic sq_en;
    } lcb_ctl_t;

endpackage

`default_nettype wire

// ===== design/lcb_in_if.sv =====
// input channel: eye and target points
`default_nettype none

interface lcb_in_if #(
    parameter int COORD_BITS = lcb_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] eye_x;
    logic signed [COORD_BITS-1:0] eye_y;
    logic signed [COORD_BITS-1:0] eye_z;
    logic signed [COORD_BITS-1:0] target_x;
    logic signed [COORD_BITS-1:0] target_y;
    logic signed [COORD_BITS-1:0] target_z;

    modport source (
        output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
        input  ready
    );
    modport sink (
        input  valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/lcb_out_if.sv =====
// output channel: camera basis
`default_nettype none

interface lcb_out_if #(
    parameter int FRAC_BITS = lcb_pkg::FRAC_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [FRAC_BITS+1:0] side_x;
    logic signed [FRAC_BITS+1:0] side_y;
    logic signed [FRAC_BITS+1:0] side_z;
    logic signed [FRAC_BITS+1:0] up_x;
    logic signed [FRAC_BITS+1:0] up_y;
    logic signed [FRAC_BITS+1:0] up_z;
    logic signed [FRAC_BITS+1:0] fwd_x;
    logic signed [FRAC_BITS+1:0] fwd_y;
    logic signed [FRAC_BITS+1:0] fwd_z;
    logic                        used_previous;

    modport source (
        output valid, side_x, side_y, side_z, up_x, up_y, up_z,
               fwd_x, fwd_y, fwd_z, used_previous,
        input  ready
    );
    modport sink (
        input  valid, side_x, side_y, side_z, up_x, up_y, up_z,
               fwd_x, fwd_y, fwd_z, used_previous,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/lookat_camera_basis_core.sv =====
// look-at camera basis: forward, side and up axes from eye and target
// from input transfer to result valid, an item passes five squares, the bit-serial divide,
// the root, four up products and the load of the result register
// one item in work at a time
// the result register lets the next item start while a result waits
// reset clears the sequencer, the output valid and the stored side vector
`default_nettype none

module lookat_camera_basis_core #(
    parameter int COORD_BITS = lcb_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = lcb_pkg::FRAC_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lcb_in_if.sink    in_ch,
    lcb_out_if.source out_ch
);

    localparam int CB  = COORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int DW  = CB + 1;
    localparam int SQW = 2*CB;
    localparam int SW  = 2*CB + 2;
    localparam int OW  = F + 2;
    localparam int PW  = 2*OW;
    localparam int QW  = 2*F + 3;
    localparam int RW  = F + 2;
    localparam int CW  = $clog2(QW + 1);
    localparam logic signed [PW:0] HALF = (PW+1)'(1) <<< (F-1);
    localparam logic signed [PW:0] ONE  = (PW+1)'(1) <<< F;

    lcb_pkg::state_t   state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    lcb_pkg::lcb_ctl_t ctl;
    logic              out_load;

    logic signed [DW-1:0] dx, dy, dz;
    logic                 deg;
    logic signed [DW-1:0] prev_x_reg, prev_z_reg;
    logic signed [DW-1:0] c_reg [5];
    logic                 used_reg;
    logic [SQW-1:0]       sq_reg [5];
    logic signed [DW-1:0] msel;
    logic [DW-1:0]        mabs;
    logic [SQW-1:0]       prod;
    logic [SW-1:0]        sum_f, sum_s;
    logic signed [OW-1:0] lane_res [5];
    logic signed [OW-1:0] ua, ub;
    logic signed [PW-1:0] p_reg [4];
    logic signed [OW-1:0] u0, u1, u2;
    logic                 out_valid_reg;

    // rounding of a product sum, halves toward plus infinity, clamped
    function automatic logic signed [OW-1:0] round_up(input logic signed [PW:0] p);
        logic signed [PW:0] x;
        logic signed [PW:0] r;
        x = p + HALF;
        r = x >>> F;
        if (r > ONE)
            r = ONE;
        if (r < -ONE)
            r = -ONE;
        return r[OW-1:0];
    endfunction

    // difference vector and side source
    assign dx  = $signed({in_ch.target_x[CB-1], in_ch.target_x})
               - $signed({in_ch.eye_x[CB-1], in_ch.eye_x});
    assign dy  = $signed({in_ch.target_y[CB-1], in_ch.target_y})
               - $signed({in_ch.eye_y[CB-1], in_ch.eye_y});
    assign dz  = $signed({in_ch.target_z[CB-1], in_ch.target_z})
               - $signed({in_ch.eye_z[CB-1], in_ch.eye_z});
    assign deg = (dx == '0) && (dz == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lcb_pkg::ST_IDLE:
                if (in_ch.valid)
                    state_next = lcb_pkg::ST_SQR;
            lcb_pkg::ST_SQR:
                if (cnt_reg == CW'(4))
                    state_next = lcb_pkg::ST_SUM;
            lcb_pkg::ST_SUM:
                state_next = lcb_pkg::ST_DIV;
            lcb_pkg::ST_DIV:
                if (cnt_reg == CW'(QW - 1))
                    state_next = lcb_pkg::ST_SQL;
            lcb_pkg::ST_SQL:
                state_next = lcb_pkg::ST_SQRT;
            lcb_pkg::ST_SQRT:
                if (cnt_reg == CW'(RW - 1))
                    state_next = lcb_pkg::ST_UPM;
            lcb_pkg::ST_UPM:
                if (cnt_reg == CW'(3))
                    state_next = lcb_pkg::ST_DONE;
            lcb_pkg::ST_DONE:
                if (!out_valid_reg || out_ch.ready)
                    state_next = lcb_pkg::ST_IDLE;
            default:
                state_next = lcb_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        ctl           = '0;
        in_ch.ready   = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            lcb_pkg::ST_IDLE:
                in_ch.ready = 1'b1;
            lcb_pkg::ST_SUM:
                ctl.load = 1'b1;
            lcb_pkg::ST_DIV:
            begin
                ctl.div_en    = 1'b1;
                ctl.div_first = (cnt_reg == '0);
            end
            lcb_pkg::ST_SQL:
                ctl.sq_load = 1'b1;
            lcb_pkg::ST_SQRT:
                ctl.sq_en = 1'b1;
            lcb_pkg::ST_DONE:
                out_load = !out_valid_reg || out_ch.ready;
            default:
                ctl = '0;
        endcase
    end

    assign cnt_next = (state_next != state_reg) ? '0 : cnt_reg + CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcb_pkg::ST_IDLE;
            cnt_reg       <= '0;
            prev_x_reg    <= '0;
            prev_z_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (in_ch.valid && in_ch.ready && !deg)
            begin
                prev_x_reg <= dz;
                prev_z_reg <= -dx;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // capture components on input transfer
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            c_reg[0] <= dx;
            c_reg[1] <= dy;
            c_reg[2] <= dz;
            c_reg[3] <= deg ? prev_x_reg : dz;
            c_reg[4] <= deg ? prev_z_reg : -dx;
            used_reg <= deg;
        end
    end

    // shared squarer, one component a cycle
    always_comb
    begin
        case (cnt_reg[2:0])
            3'd0:    msel = c_reg[0];
            3'd1:    msel = c_reg[1];
            3'd2:    msel = c_reg[2];
            3'd3:    msel = c_reg[3];
            default: msel = c_reg[4];
        endcase
    end

    assign mabs = msel[DW-1] ? DW'(-msel) : DW'(msel);
    assign prod = mabs[CB-1:0] * mabs[CB-1:0];

    always_ff @(posedge clk)
    begin
        if (state_reg == lcb_pkg::ST_SQR)
        begin
            case (cnt_reg[2:0])
                3'd0:    sq_reg[0] <= prod;
                3'd1:    sq_reg[1] <= prod;
                3'd2:    sq_reg[2] <= prod;
                3'd3:    sq_reg[3] <= prod;
                default: sq_reg[4] <= prod;
            endcase
        end
    end

    // squared lengths of forward and side vectors
    assign sum_f = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
    assign sum_s = SW'(sq_reg[3]) + SW'(sq_reg[4]);

    // five normalize lanes in parallel
    for (genvar i = 0; i < 5; i++)
    begin : g_lane
        lcb_norm #(
            .COORD_BITS (COORD_BITS),
            .FRAC_BITS  (FRAC_BITS)
        ) u_norm (
            .clk (clk),
            .ctl (ctl),
            .sq  (sq_reg[i]),
            .sum ((i < 3) ? sum_f : sum_s),
            .neg (c_reg[i][DW-1]),
            .res (lane_res[i])
        );
    end

    // up axis products, one a cycle
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:
            begin
                ua = lane_res[1];
                ub = lane_res[4];
            end
            2'd1:
            begin
                ua = lane_res[2];
                ub = lane_res[3];
            end
            2'd2:
            begin
                ua = lane_res[0];
                ub = lane_res[4];
            end
            default:
            begin
                ua = lane_res[1];
                ub = lane_res[3];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == lcb_pkg::ST_UPM)
        begin
            case (cnt_reg[1:0])
                2'd0:    p_reg[0] <= ua * ub;
                2'd1:    p_reg[1] <= ua * ub;
                2'd2:    p_reg[2] <= ua * ub;
                default: p_reg[3] <= ua * ub;
            endcase
        end
    end

    assign u0 = round_up({p_reg[0][PW-1], p_reg[0]});
    assign u1 = round_up({p_reg[1][PW-1], p_reg[1]} - {p_reg[2][PW-1], p_reg[2]});
    assign u2 = round_up(-{p_reg[3][PW-1], p_reg[3]});

    // result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ch.side_x        <= lane_res[3];
            out_ch.side_y        <= '0;
            out_ch.side_z        <= lane_res[4];
            out_ch.up_x          <= u0;
            out_ch.up_y          <= u1;
            out_ch.up_z          <= u2;
            out_ch.fwd_x         <= lane_res[0];
            out_ch.fwd_y         <= lane_res[1];
            out_ch.fwd_z         <= lane_res[2];
            out_ch.used_previous <= used_reg;
        end
    end

    assign out_ch.valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== design/lcb_norm.sv =====
// one normalize lane: bit-serial divide then digit-serial square root
`default_nettype none

module lcb_norm #(
    parameter int COORD_BITS = lcb_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = lcb_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire lcb_pkg::lcb_ctl_t                ctl,
    input  wire logic [2*COORD_BITS-1:0]          sq,
    input  wire logic [2*COORD_BITS+1:0]          sum,
    input  wire logic                             neg,
    output logic signed [FRAC_BITS+1:0]           res
);

    localparam int SW = 2*COORD_BITS + 2;
    localparam int QW = 2*FRAC_BITS + 3;
    localparam int RW = FRAC_BITS + 2;

    logic [SW-1:0]   sum_reg;
    logic [SW:0]     rem_reg;
    logic [QW-1:0]   quo_reg;
    logic [2*RW-1:0] qsh_reg;
    logic [RW+1:0]   srem_reg;
    logic [RW-1:0]   root_reg;
    logic            neg_reg;
    logic            zero_reg;

    logic [SW:0]     trial;
    logic            dge;
    logic [RW+3:0]   stmp;
    logic [RW+3:0]   sdiv;
    logic            sge;
    logic [RW:0]     rnd;
    logic [RW-1:0]   mag;

    // quotient step: floor(sq * 2^(2F+2) / sum), one bit a cycle
    assign trial = ctl.div_first ? rem_reg : {rem_reg[SW-1:0], 1'b0};
    assign dge   = trial >= {1'b0, sum_reg};

    // root step: two quotient bits a cycle
    assign stmp = {srem_reg, qsh_reg[2*RW-1 -: 2]};
    assign sdiv = {2'b00, root_reg, 2'b01};
    assign sge  = stmp >= sdiv;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            sum_reg  <= sum;
            rem_reg  <= {{(SW+1-2*COORD_BITS){1'b0}}, sq};
            quo_reg  <= '0;
            neg_reg  <= neg;
            zero_reg <= (sum == '0);
        end
        else if (ctl.div_en)
        begin
            rem_reg <= dge ? (trial - {1'b0, sum_reg}) : trial;
            quo_reg <= {quo_reg[QW-2:0], dge};
        end

        if (ctl.sq_load)
        begin
            qsh_reg  <= {{(2*RW-QW){1'b0}}, quo_reg};
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (ctl.sq_en)
        begin
            qsh_reg  <= {qsh_reg[2*RW-3:0], 2'b00};
            srem_reg <= sge ? (stmp[RW+1:0] - sdiv[RW+1:0]) : stmp[RW+1:0];
            root_reg <= {root_reg[RW-2:0], sge};
        end
    end

    // adding one to the root and dropping its low bit gives the rounded magnitude
    assign rnd = {1'b0, root_reg} + (RW+1)'(1);
    assign mag = rnd[RW:1];

    always_comb
    begin
        if (zero_reg)
            res = '0;
        else if (neg_reg)
            res = -$signed(mag);
        else
            res = $signed(mag);
    end

endmodule

`default_nettype wire
